// ===== rtl/sasp_pkg.sv =====
// package for the servo adaptive slew pwm block
// types, state encoding and fixed constants; no dependencies
package sasp_pkg;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIST,
    ST_EMIT,
    ST_STEP
  } sasp_state_t;

  // request to the shared add/subtract unit
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic       sub;
  } sasp_alu_req_t;

  localparam logic [7:0]  ANGLE_MAX    = 8'd180;
  localparam logic [7:0]  NEAR_LIMIT   = 8'd30;
  localparam logic [7:0]  MID_LIMIT    = 8'd100;
  localparam logic [4:0]  STEP_FINE    = 5'd1;
  localparam logic [4:0]  STEP_MID     = 5'd5;
  localparam logic [4:0]  STEP_COARSE  = 5'd20;
  localparam logic [11:0] PWM_BASE     = 12'd500;
  // round(2000/180 * 2^16), exact floor over angles 0..180
  localparam logic [19:0] PWM_RECIP    = 20'd728178;
  localparam int          PWM_SHIFT    = 16;
  localparam logic [5:0]  RESULT_LIMIT = 6'd49;

endpackage

// ===== rtl/sasp_alu.sv =====
// shared 8-bit add/subtract unit used for distance and for walking
// depends on sasp_pkg
module sasp_alu
  import sasp_pkg::*;
(
  input  sasp_alu_req_t req,
  output logic [7:0]    res
);

  // adds, or subtracts b from a when sub is set
  assign res = req.sub ? (req.a - req.b) : (req.a + req.b);

endmodule

// ===== rtl/sasp_pwm.sv =====
// angle to timer compare conversion by reciprocal multiply
// depends on sasp_pkg
module sasp_pwm
  import sasp_pkg::*;
(
  input  logic [7:0]  angle,
  output logic [11:0] compare
);

  logic [27:0] prod;

  // angle*2000/180 as multiply and shift
  assign prod    = {20'd0, angle} * {8'd0, PWM_RECIP};
  assign compare = prod[PWM_SHIFT +: 12] + PWM_BASE;

endmodule

// ===== rtl/servo_adaptive_slew_pwm.sv =====
// top level: servo slew limiter with adaptive step, emitting pwm compare values
// depends on sasp_pkg, sasp_alu, sasp_pwm
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata[7:0] target_angle
//  out_    | out | out_tvalid/tready  | tdata[11:0] pwm_compare, [19:12] point_angle,
//          |     |                    | tlast last_point
//
// each point passes through ST_DIST, ST_EMIT and ST_STEP: distance and step through the
// shared adder into the output register, the result transaction, then the walk
// update through the same adder; the last point skips the update
// a move emits at most RESULT_LIMIT points
// out_tready low holds the point in the output register and stalls the walk
// in_tready is high only between moves; rst_n returns the held angle to zero
module servo_adaptive_slew_pwm
  import sasp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] target_angle
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [11:0] pwm_compare, [19:12] point_angle, [23:20] zero
  output logic        out_tlast   // last_point
);

  sasp_state_t   state_r, state_nxt;
  logic [7:0]    held_r, held_nxt;
  logic [7:0]    target_r, target_nxt;
  logic [7:0]    walk_r, walk_nxt;
  logic [4:0]    step_r, step_nxt;
  logic          down_r, down_nxt;
  logic [5:0]    count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [11:0]   out_pwm_r, out_pwm_nxt;
  logic [7:0]    out_angle_r, out_angle_nxt;
  logic          out_last_r, out_last_nxt;

  sasp_alu_req_t alu_req;
  logic [7:0]    alu_res;
  logic [11:0]   pwm_val;
  logic [7:0]    target_sat;
  logic [4:0]    step_pick;
  logic          last_pt;

  // shared arithmetic and compare conversion
  sasp_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  sasp_pwm u_pwm (
    .angle   (walk_r),
    .compare (pwm_val)
  );

  // input saturation
  assign target_sat = (in_tdata > ANGLE_MAX) ? ANGLE_MAX : in_tdata;

  // step choice from the remaining distance; a distance of ANGLE_MAX or more keeps the step
  always_comb begin
    priority if (alu_res < NEAR_LIMIT) begin
      step_pick = STEP_FINE;
    end else if (alu_res < MID_LIMIT) begin
      step_pick = STEP_MID;
    end else if (alu_res < ANGLE_MAX) begin
      step_pick = STEP_COARSE;
    end else begin
      step_pick = step_r;
    end
  end

  assign last_pt = ({3'd0, step_pick} > alu_res) || (count_r == RESULT_LIMIT - 6'd1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_DIST;
      ST_DIST: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_tready) state_nxt = out_last_r ? ST_IDLE : ST_STEP;
      end
      ST_STEP: state_nxt = ST_DIST;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // shared unit operands: walk update in step state, distance otherwise
  always_comb begin
    if (state_r == ST_STEP) begin
      alu_req.a   = walk_r;
      alu_req.b   = {3'd0, step_r};
      alu_req.sub = down_r;
    end else begin
      alu_req.a   = down_r ? walk_r : target_r;
      alu_req.b   = down_r ? target_r : walk_r;
      alu_req.sub = 1'b1;
    end
  end

  // datapath register updates
  always_comb begin
    held_nxt      = held_r;
    target_nxt    = target_r;
    walk_nxt      = walk_r;
    step_nxt      = step_r;
    down_nxt      = down_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_pwm_nxt   = out_pwm_r;
    out_angle_nxt = out_angle_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          target_nxt = target_sat;
          down_nxt   = held_r >= target_sat;
          walk_nxt   = held_r;
          step_nxt   = STEP_FINE;
          count_nxt  = 6'd0;
        end
      end
      ST_DIST: begin
        step_nxt      = step_pick;
        out_valid_nxt = 1'b1;
        out_pwm_nxt   = pwm_val;
        out_angle_nxt = walk_r;
        out_last_nxt  = last_pt;
      end
      ST_EMIT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) held_nxt = target_r;
        end
      end
      ST_STEP: begin
        walk_nxt  = alu_res;
        count_nxt = count_r + 6'd1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= 8'd0;
      walk_r      <= 8'd0;
      step_r      <= STEP_FINE;
      count_r     <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      walk_r      <= walk_nxt;
      step_r      <= step_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    target_r    <= target_nxt;
    down_r      <= down_nxt;
    out_pwm_r   <= out_pwm_nxt;
    out_angle_r <= out_angle_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_angle_r, out_pwm_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/sasp_checker.sv =====
// port-level checks for servo_adaptive_slew_pwm, bound to the top level
// depends on servo_adaptive_slew_pwm ports only
module sasp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  // a stalled result transaction holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // no new target is taken while a point waits
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input ready while result pending");

  // an accepted target starts a move, so the input closes
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input stayed ready after accept");

  // emitted angle within range and padding zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[19:12] <= 8'd180) && (out_tdata[23:20] == 4'd0))
    else $error("result angle out of range");

endmodule

bind servo_adaptive_slew_pwm sasp_checker u_sasp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== tb/servo_adaptive_slew_pwm_tb.sv =====
// self-checking testbench for servo_adaptive_slew_pwm
// depends on sasp_pkg and the servo_adaptive_slew_pwm rtl; needs no files or arguments
module servo_adaptive_slew_pwm_tb;
  import sasp_pkg::*;

  // one point of a move, as carried by the result channel
  typedef struct packed {
    logic [11:0] pwm;
    logic [7:0]  angle;
    logic        last;
  } point_t;

  // directed row: target, and a typed single-point result where it is obvious
  typedef struct packed {
    logic [7:0]  target;
    logic        typed;
    logic [11:0] pwm;
    logic [7:0]  angle;
  } target_row_t;

  localparam int N_DIRECTED  = 22;
  localparam int N_PER_PHASE = 65;
  localparam int HOLD_AT     = N_DIRECTED + 20;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 200000;
  localparam int SETTLE      = 200;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tlast;

  // predictor state and the store of points still to arrive
  logic [7:0]  held_deg;
  point_t      move_points [0:48];
  point_t      expected_points [$];

  int          errors;
  int          targets_taken;
  int          points_seen;
  int          longest_move;
  int          clipped_targets;
  int          idle_pct;
  int          stall_pct;
  int          hold_left;
  bit          hold_done;

  target_row_t directed [0:N_DIRECTED-1];

  servo_adaptive_slew_pwm uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #(8 * 2000000);
    $display("servo_adaptive_slew_pwm: mismatch");
    $finish;
  end

  // compare value for an angle: angle*2000/180 truncated, plus base
  function automatic logic [11:0] pwm_of(input logic [7:0] deg);
    int prod;
    prod = int'(deg) * 2000;
    return 12'(prod / int'(ANGLE_MAX) + int'(PWM_BASE));
  endfunction

  // walk from the held angle to the clipped target, fill move_points, return the count
  function automatic int plan_walk(input logic [7:0] raw);
    logic [7:0] tgt;
    logic [7:0] pos;
    logic [7:0] gap;
    logic [4:0] stp;
    logic       down;
    logic       fin;
    int         n;
    tgt  = (raw > ANGLE_MAX) ? ANGLE_MAX : raw;
    down = (held_deg >= tgt);
    pos  = held_deg;
    stp  = STEP_FINE;
    n    = 0;
    fin  = 1'b0;
    while (!fin) begin
      gap = down ? pos - tgt : tgt - pos;
      // step picked from the remaining distance; full span keeps the previous one
      if (gap < NEAR_LIMIT) stp = STEP_FINE;
      else if (gap < MID_LIMIT) stp = STEP_MID;
      else if (gap < ANGLE_MAX) stp = STEP_COARSE;
      fin = ({3'b000, stp} > gap) || (n == int'(RESULT_LIMIT) - 1);
      move_points[n] = '{pwm: pwm_of(pos), angle: pos, last: fin};
      n++;
      if (!fin) pos = down ? pos - {3'b000, stp} : pos + {3'b000, stp};
    end
    held_deg = tgt;
    return n;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // one transaction on the input channel, with optional idle cycles first
  task automatic offer_target(input logic [7:0] tgt);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= tgt;
    do @(posedge clk); while (!in_tready);
  endtask

  // record an accepted target: predicted points, or the typed single point
  task automatic take_target(input logic [7:0] tgt, input target_row_t row, input bit typed);
    int n;
    n = plan_walk(tgt);
    targets_taken++;
    if (tgt > ANGLE_MAX) clipped_targets++;
    if (n > longest_move) longest_move = n;
    if (typed) begin
      expected_points.push_back('{pwm: row.pwm, angle: row.angle, last: 1'b1});
    end else begin
      for (int i = 0; i < n; i++) expected_points.push_back(move_points[i]);
    end
  endtask

  // random target: near the held angle, extremes, above range, or anywhere
  function automatic logic [7:0] pick_target();
    int sel;
    int off;
    sel = $urandom_range(99);
    off = $urandom_range(35);
    if (sel < 20) begin
      if ($urandom_range(1) == 0)
        return (int'(held_deg) + off > 180) ? 8'd180 : 8'(int'(held_deg) + off);
      return (int'(held_deg) < off) ? 8'd0 : 8'(int'(held_deg) - off);
    end
    if (sel < 35) return ($urandom_range(1) == 0) ? 8'd0 : ANGLE_MAX;
    if (sel < 45) return 8'($urandom_range(255, 181));
    if (sel < 85) return 8'($urandom_range(180));
    return 8'($urandom_range(255));
  endfunction

  // result channel: ready with random stalls, and one long hold-off
  initial begin
    out_tready = 1'b0;
    hold_left  = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && targets_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // check each result transaction against the oldest expected point
  initial begin
    point_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        points_seen++;
        if (expected_points.size() == 0) begin
          report_mismatch("point with nothing expected, angle", out_tdata[19:12], 0);
        end else begin
          want = expected_points.pop_front();
          if (out_tdata[11:0] !== want.pwm)
            report_mismatch("pwm_compare", out_tdata[11:0], want.pwm);
          if (out_tdata[19:12] !== want.angle)
            report_mismatch("point_angle", out_tdata[19:12], want.angle);
          if (out_tlast !== want.last)
            report_mismatch("last_point", out_tlast, want.last);
          if (out_tdata[23:20] !== 4'h0)
            report_mismatch("tdata padding", out_tdata[23:20], 0);
        end
      end
    end
  end

  // stimulus
  initial begin
    int guard;
    int idle_by_phase [0:3];
    int stall_by_phase [0:3];
    logic [7:0] tgt;
    target_row_t none;

    idle_by_phase  = '{0, 60, 0, 19};
    stall_by_phase = '{0, 0, 60, 19};
    none = '0;

    // target, typed, pwm, angle
    directed = '{
      '{8'd0,   1'b1, 12'd500,  8'd0},    // equal target right after reset
      '{8'd180, 1'b0, 12'd0,    8'd0},    // full span, keeps the start step
      '{8'd180, 1'b1, 12'd2500, 8'd180},  // equal target at the top
      '{8'd255, 1'b1, 12'd2500, 8'd180},  // above range, saturates to 180, the held angle
      '{8'd181, 1'b1, 12'd2500, 8'd180},  // just above range
      '{8'd0,   1'b0, 12'd0,    8'd0},    // full span downward
      '{8'd29,  1'b0, 12'd0,    8'd0},    // fine step only
      '{8'd59,  1'b0, 12'd0,    8'd0},    // distance 30
      '{8'd158, 1'b0, 12'd0,    8'd0},    // distance 99
      '{8'd58,  1'b0, 12'd0,    8'd0},    // distance 100 downward
      '{8'd237, 1'b0, 12'd0,    8'd0},    // above range after a move
      '{8'd1,   1'b0, 12'd0,    8'd0},    // distance 179 downward
      '{8'd0,   1'b0, 12'd0,    8'd0},    // distance 1
      '{8'd128, 1'b0, 12'd0,    8'd0},
      '{8'd127, 1'b0, 12'd0,    8'd0},
      '{8'd64,  1'b0, 12'd0,    8'd0},
      '{8'd90,  1'b0, 12'd0,    8'd0},
      '{8'd9,   1'b0, 12'd0,    8'd0},
      '{8'd9,   1'b1, 12'd600,  8'd9},    // equal target mid range
      '{8'd170, 1'b0, 12'd0,    8'd0},
      '{8'd85,  1'b0, 12'd0,    8'd0},
      '{8'd200, 1'b0, 12'd0,    8'd0}
    };

    errors          = 0;
    targets_taken   = 0;
    points_seen     = 0;
    longest_move    = 0;
    clipped_targets = 0;
    idle_pct        = 0;
    stall_pct       = 0;
    held_deg        = 8'd0;
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = 8'd0;

    // reset
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed targets, no idling
    for (int i = 0; i < N_DIRECTED; i++) begin
      offer_target(directed[i].target);
      take_target(directed[i].target, directed[i], directed[i].typed);
    end

    // random targets over the idle and stall phases
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      for (int i = 0; i < N_PER_PHASE; i++) begin
        tgt = pick_target();
        offer_target(tgt);
        take_target(tgt, none, 1'b0);
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    // drain, then settle for the longest move
    guard = 0;
    while (expected_points.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);

    if (expected_points.size() != 0)
      report_mismatch("points never delivered", 0, expected_points.size());

    $display("covered %0d targets (%0d above range) and %0d points, longest move %0d points",
             targets_taken, clipped_targets, points_seen, longest_move);
    $display("phases: free flow, sender gaps, receiver stalls, both, plus a long hold-off");
    if (errors == 0) begin
      $display("servo_adaptive_slew_pwm: match");
    end else begin
      $display("servo_adaptive_slew_pwm: mismatch");
    end
    $finish;
  end

endmodule
